>>> rtl/core/ale_pkg.sv
// ale_pkg: shared types, codes and list capacity for the array list engine.
// No dependencies.
package ale_pkg;

  // list capacity; position and found_index span 0..255, element_count holds 256
  localparam int DEPTH = 256;

  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_POP_BACK   = 3'd1,
    KIND_PUSH_FRONT = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_INSERT     = 3'd4,
    KIND_ERASE      = 3'd5,
    KIND_FIND       = 3'd6,
    KIND_CLEAR      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture command, set up first step
    logic rd_step;   // issue read at walk pointer, advance
    logic wr_shift;  // write data read last step, one place over
    logic wr_value;  // write command value at target slot
    logic finish;    // register result and update count
    logic match_hit; // record found index
  } ale_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk_done;  // walk pointer reached its end
    logic is_match;   // read data equals value
    logic need_shift; // command needs a walk of the store (shift or find)
  } ale_stat_t;

endpackage

>>> rtl/core/ale_ram.sv
// ale_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
module ale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/ale_datapath.sv
// ale_datapath: command registers, count, walk pointer, store and result.
// Depends on ale_pkg and ale_ram.
module ale_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic [2:0]          kind,
  input  logic [7:0]          position,
  input  logic signed [31:0]  value,
  input  ale_pkg::ale_cmd_t   cmd,
  output ale_pkg::ale_stat_t  stat,
  output logic [2:0]          status,
  output logic [7:0]          found_index,
  output logic [8:0]          element_count
);
  localparam int DEPTH = ale_pkg::DEPTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [2:0]    op;
  logic [CW-1:0] pos;
  logic [31:0]   val;
  logic [CW-1:0] ptr;      // next read address
  logic [CW-1:0] last_rd;  // address of data now on rdata
  logic [CW-1:0] stop;     // walk ends at ptr == stop (up: stop - 1)
  logic          up;       // walk downward (shift up)
  logic [2:0]    res;
  logic [CW-1:0] found;

  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  logic [CW-1:0] pos_in;
  logic          good;

  assign pos_in = CW'(position);

  ale_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(ptr[AW-1:0]), .rdata(rdata)
  );

  // outcome decided at load
  always_comb begin
    res  = ale_pkg::ST_OK;
    good = 1'b0;
    case (kind)
      ale_pkg::KIND_PUSH_BACK, ale_pkg::KIND_PUSH_FRONT: begin
        if (count == CW'(DEPTH)) res = ale_pkg::ST_FULL;
        else good = 1'b1;
      end
      ale_pkg::KIND_POP_BACK, ale_pkg::KIND_POP_FRONT: begin
        if (count == '0) res = ale_pkg::ST_EMPTY;
        else good = 1'b1;
      end
      ale_pkg::KIND_INSERT: begin
        if (pos_in > count) res = ale_pkg::ST_BADPOS;
        else if (count == CW'(DEPTH)) res = ale_pkg::ST_FULL;
        else good = 1'b1;
      end
      ale_pkg::KIND_ERASE: begin
        if (pos_in >= count) res = ale_pkg::ST_BADPOS;
        else good = 1'b1;
      end
      ale_pkg::KIND_FIND: res = ale_pkg::ST_NOTFOUND;
      default: good = 1'b1;
    endcase
  end

  logic [2:0] res_r;
  logic       good_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
    if (cmd.load) begin
      op     <= kind;
      val    <= value;
      res_r  <= res;
      good_r <= good;
      found  <= '0;
      case (kind)
        ale_pkg::KIND_PUSH_FRONT: begin
          pos <= '0; up <= 1'b1; ptr <= count - CW'(1); stop <= '0;
        end
        ale_pkg::KIND_INSERT: begin
          pos <= pos_in; up <= 1'b1; ptr <= count - CW'(1); stop <= pos_in;
        end
        ale_pkg::KIND_POP_FRONT: begin
          pos <= '0; up <= 1'b0; ptr <= CW'(1); stop <= count;
        end
        ale_pkg::KIND_ERASE: begin
          pos <= pos_in; up <= 1'b0; ptr <= pos_in + CW'(1); stop <= count;
        end
        default: begin
          pos <= count; up <= 1'b0; ptr <= '0; stop <= count;
        end
      endcase
    end else if (cmd.rd_step) begin
      last_rd <= ptr;
      ptr     <= up ? ptr - CW'(1) : ptr + CW'(1);
    end
    if (cmd.match_hit) begin
      found <= last_rd;
      res_r <= ale_pkg::ST_OK;
    end
    if (cmd.finish) begin
      status        <= res_r;
      found_index   <= found[7:0];
      element_count <= 9'(count_next);
    end
  end

  // walk is done when the next read would leave the range
  assign stat.walk_done  = up ? ((ptr + CW'(1)) == stop) : (ptr == stop);
  assign stat.is_match   = (rdata == val);
  // find walks only valid entries, so an empty list is never searched
  assign stat.need_shift = (good_r && (
    ((op == ale_pkg::KIND_PUSH_FRONT || op == ale_pkg::KIND_INSERT) && count != pos) ||
    ((op == ale_pkg::KIND_POP_FRONT || op == ale_pkg::KIND_ERASE)
      && (pos + CW'(1)) != count))) ||
    (op == ale_pkg::KIND_FIND && count != '0);

  // only pushes and inserts store the command value
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = val;
    if (cmd.wr_shift) begin
      we    = 1'b1;
      wdata = rdata;
      waddr = up ? AW'(last_rd + CW'(1)) : AW'(last_rd - CW'(1));
    end else if (cmd.wr_value && good_r && (op == ale_pkg::KIND_PUSH_BACK ||
               op == ale_pkg::KIND_PUSH_FRONT || op == ale_pkg::KIND_INSERT)) begin
      we    = 1'b1;
      waddr = AW'(pos);
    end
  end

  always_comb begin
    count_next = count;
    if (good_r) begin
      case (op)
        ale_pkg::KIND_PUSH_BACK, ale_pkg::KIND_PUSH_FRONT, ale_pkg::KIND_INSERT:
          count_next = count + CW'(1);
        ale_pkg::KIND_POP_BACK, ale_pkg::KIND_POP_FRONT, ale_pkg::KIND_ERASE:
          count_next = count - CW'(1);
        ale_pkg::KIND_CLEAR: count_next = '0;
        default: count_next = count;
      endcase
    end
  end
endmodule

>>> rtl/core/ale_ctrl.sv
// ale_ctrl: sequencer for one command: load, walk the store, write, finish.
// Depends on ale_pkg.
module ale_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         kind,
  input  ale_pkg::ale_stat_t stat,
  output ale_pkg::ale_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_READ  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_PUT   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   is_find;
  logic   is_find_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      is_find <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      is_find <= is_find_next;
      done    <= cmd.finish;
    end
  end

  assign busy = (state != S_IDLE);

  // S_CHECK issues the first read; S_MOVE sees its data, writes or compares, and
  // issues the next read when more remain.
  always_comb begin
    cmd          = '0;
    state_next   = state;
    is_find_next = is_find;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          is_find_next = (kind == ale_pkg::KIND_FIND);
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.need_shift) begin
          cmd.rd_step = 1'b1;
          state_next  = S_MOVE;
        end else begin
          state_next = S_PUT;
        end
      end
      S_MOVE: begin
        if (is_find) begin
          if (stat.is_match) begin
            cmd.match_hit = 1'b1;
            state_next    = S_DONE;
          end else if (stat.walk_done) begin
            state_next = S_DONE;
          end else begin
            cmd.rd_step = 1'b1;
          end
        end else begin
          cmd.wr_shift = 1'b1;
          if (stat.walk_done) state_next = S_PUT;
          else cmd.rd_step = 1'b1;
        end
      end
      S_PUT: begin
        cmd.wr_value = !is_find;
        state_next   = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_READ: state_next = S_MOVE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> rtl/core/array_list_engine_unit.sv
// array_list_engine_unit: top level of the array list engine.
// Depends on ale_pkg, ale_ctrl, ale_datapath (and ale_ram below it).
//
// Usage:
//  - Command channel: drive kind/position/value and raise start; the item is
//    taken on a rising edge where start is high and busy is low.
//  - Result channel: done pulses for one cycle with status, found_index and
//    element_count. The receiver must take it in that cycle; it cannot stall.
//  - Commands that move nothing skip the walk of the store (push back, pop
//    back, clear, failed checks, end-of-list inserts and erases, find on an
//    empty list). Shifts walk the store through the one RAM read port, one
//    entry per cycle, so their cost grows with the entries moved; a find
//    walks until it hits or has read every entry. Worst cases: a missed find
//    in a full list and any shift of DEPTH - 1 entries (to or from slot 0).
//  - One command in flight at a time; busy stays high until the result, and
//    the next item can be taken in the cycle done is high.
//  - Reset (rst, synchronous) empties the list; store contents are not
//    cleared and need no clearing pass since only entries below the count
//    are ever read.
module array_list_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         kind,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               done,
  output logic [2:0]         status,
  output logic [7:0]         found_index,
  output logic [8:0]         element_count
);
  ale_pkg::ale_cmd_t  cmd;
  ale_pkg::ale_stat_t stat;

  ale_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .kind(kind),
    .stat(stat), .cmd(cmd), .busy(busy), .done(done)
  );

  ale_datapath u_dp (
    .clk(clk), .rst(rst), .kind(kind), .position(position), .value(value),
    .cmd(cmd), .stat(stat), .status(status), .found_index(found_index),
    .element_count(element_count)
  );

  // a result only follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without command");

  // no store writes while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !(cmd.wr_shift || cmd.wr_value)) else $error("write while idle");

  // count never exceeds capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> element_count <= 9'(ale_pkg::DEPTH)) else $error("count overflow");
endmodule

>>> tb/tb.sv
// tb: self-checking testbench for array_list_engine_unit.
// Depends on ale_pkg and the engine RTL; runs directed items, a fill to full
// and random items, checked against a behavioral list model or, for typed rows, their written results.
module tb;

  localparam int LIST_DEPTH = 256;
  localparam int QUIET_LIMIT = 4000; // cycles with no handshake at all
  localparam int TAIL_CYCLES = 300;  // beyond the worst command latency

  typedef struct {
    ale_pkg::kind_t       kind;
    logic [7:0]           pos;
    logic signed [31:0]   val;
    bit                   typed;     // expected result written in the row
    ale_pkg::status_t     st;
    logic [7:0]           idx;
    logic [8:0]           cnt;
  } row_t;

  typedef struct {
    ale_pkg::status_t st;
    logic [7:0]       idx;
    logic [8:0]       cnt;
  } outcome_t;

  logic               clk, rst, start, busy, done;
  logic [2:0]         kind, status;
  logic [7:0]         position, found_index;
  logic signed [31:0] value;
  logic [8:0]         element_count;

  // typed expectation travels with the item on the input side
  bit         row_typed;
  outcome_t   row_outcome;

  array_list_engine_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .kind(kind), .position(position), .value(value),
    .done(done), .status(status), .found_index(found_index),
    .element_count(element_count)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // list model
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int unsigned        shadow_count;
  outcome_t           pending_results [$];
  int                 fail_count;
  int                 quiet_cycles;

  function automatic outcome_t apply_command(ale_pkg::kind_t k, int unsigned p,
                                             logic signed [31:0] v);
    outcome_t r;
    r.st = ale_pkg::ST_OK;
    r.idx = '0;
    case (k)
      ale_pkg::KIND_PUSH_BACK, ale_pkg::KIND_PUSH_FRONT, ale_pkg::KIND_INSERT: begin
        if (k == ale_pkg::KIND_PUSH_BACK) p = shadow_count;
        if (k == ale_pkg::KIND_PUSH_FRONT) p = 0;
        if (p > shadow_count) r.st = ale_pkg::ST_BADPOS;
        else if (shadow_count >= LIST_DEPTH) r.st = ale_pkg::ST_FULL;
        else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = v;
          shadow_count++;
        end
      end
      ale_pkg::KIND_POP_BACK, ale_pkg::KIND_POP_FRONT, ale_pkg::KIND_ERASE: begin
        if (k == ale_pkg::KIND_POP_FRONT) p = 0;
        if (k != ale_pkg::KIND_ERASE && shadow_count == 0) r.st = ale_pkg::ST_EMPTY;
        else if (k == ale_pkg::KIND_ERASE && p >= shadow_count) r.st = ale_pkg::ST_BADPOS;
        else begin
          if (k != ale_pkg::KIND_POP_BACK)
            for (int i = p + 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
          shadow_count--;
        end
      end
      ale_pkg::KIND_FIND: begin
        r.st = ale_pkg::ST_NOTFOUND;
        for (int i = 0; i < shadow_count; i++)
          if (shadow_list[i] == v) begin
            r.st = ale_pkg::ST_OK;
            r.idx = i[7:0];
            break;
          end
      end
      default: shadow_count = 0;
    endcase
    r.cnt = shadow_count[8:0];
    return r;
  endfunction

  // capture accepted items, check results, watchdog
  always @(posedge clk) begin
    outcome_t want, got;
    int quiet;
    if (!rst) begin
      quiet = quiet_cycles + 1;
      if (start && !busy) begin
        want = apply_command(ale_pkg::kind_t'(kind), position, value);
        if (row_typed) want = row_outcome;
        pending_results.push_back(want);
        quiet = 0;
      end
      if (done) begin
        quiet = 0;
        got.st = ale_pkg::status_t'(status);
        got.idx = found_index;
        got.cnt = element_count;
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: status %0d", status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.st !== want.st) begin
            $error("status: expected %0d actual %0d", want.st, status);
            fail_count++;
          end
          if (got.idx !== want.idx) begin
            $error("found_index: expected %0d actual %0d", want.idx, found_index);
            fail_count++;
          end
          if (got.cnt !== want.cnt) begin
            $error("element_count: expected %0d actual %0d", want.cnt, element_count);
            fail_count++;
          end
        end
      end
      quiet_cycles <= quiet;
      if (quiet >= QUIET_LIMIT) begin
        $display("array_list_engine_unit test failed");
        $finish;
      end
    end
  end

  bit idle_ok;

  // present one item and hold it until taken
  task automatic issue(ale_pkg::kind_t k, logic [7:0] p, logic signed [31:0] v,
                       bit typed = 0, outcome_t o = '{ale_pkg::ST_OK, 8'd0, 9'd0});
    int gap;
    if (idle_ok && $urandom_range(99) < 29) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    kind <= k;
    position <= p;
    value <= v;
    row_typed <= typed;
    row_outcome <= o;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  function automatic logic signed [31:0] any_word();
    case ($urandom_range(7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return $urandom_range(4);
      default: return $urandom();
    endcase
  endfunction

  row_t directed [] = '{
    '{ale_pkg::KIND_POP_BACK,   8'd0,   32'sd0,         1, ale_pkg::ST_EMPTY,    8'd0, 9'd0},
    '{ale_pkg::KIND_POP_FRONT,  8'd0,   32'sd0,         1, ale_pkg::ST_EMPTY,    8'd0, 9'd0},
    '{ale_pkg::KIND_ERASE,      8'd0,   32'sd0,         1, ale_pkg::ST_BADPOS,   8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   32'sd5,         1, ale_pkg::ST_NOTFOUND, 8'd0, 9'd0},
    '{ale_pkg::KIND_INSERT,     8'd1,   32'sd9,         1, ale_pkg::ST_BADPOS,   8'd0, 9'd0},
    '{ale_pkg::KIND_INSERT,     8'd255, -32'sd1,        1, ale_pkg::ST_BADPOS,   8'd0, 9'd0},
    '{ale_pkg::KIND_PUSH_BACK,  8'd255, 32'sh7fff_ffff, 1, ale_pkg::ST_OK,       8'd0, 9'd1},
    '{ale_pkg::KIND_PUSH_FRONT, 8'd0,   32'sh8000_0000, 1, ale_pkg::ST_OK,       8'd0, 9'd2},
    '{ale_pkg::KIND_INSERT,     8'd2,   -32'sd1,        1, ale_pkg::ST_OK,       8'd0, 9'd3},
    '{ale_pkg::KIND_INSERT,     8'd0,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_INSERT,     8'd2,   32'sd7,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   -32'sd1,        0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   32'sh8000_0000, 0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   32'sd1234,      0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_ERASE,      8'd5,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_ERASE,      8'd1,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_ERASE,      8'd3,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_POP_FRONT,  8'd0,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_POP_BACK,   8'd0,   32'sd0,         0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   32'sh7fff_ffff, 0, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_CLEAR,      8'd0,   32'sd0,         1, ale_pkg::ST_OK,       8'd0, 9'd0},
    '{ale_pkg::KIND_FIND,       8'd0,   -32'sd1,        1, ale_pkg::ST_NOTFOUND, 8'd0, 9'd0}
  };

  initial begin
    ale_pkg::kind_t k;
    int unsigned n, p;
    logic signed [31:0] v;
    fail_count = 0;
    quiet_cycles = 0;
    shadow_count = 0;
    idle_ok = 1;
    rst = 1'b1;
    start = 1'b0;
    kind = '0;
    position = '0;
    value = '0;
    row_typed = 0;
    row_outcome = '{ale_pkg::ST_OK, 8'd0, 9'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      issue(directed[i].kind, directed[i].pos, directed[i].val, directed[i].typed,
            '{directed[i].st, directed[i].idx, directed[i].cnt});
    row_typed <= 0;

    // hold off until the engine has drained everything
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);

    // fill to capacity without idling, then hit every full case
    idle_ok = 0;
    issue(ale_pkg::KIND_CLEAR, 8'd0, 32'sd0);
    for (int i = 0; i < LIST_DEPTH; i++)
      issue(i[0] ? ale_pkg::KIND_PUSH_FRONT : ale_pkg::KIND_PUSH_BACK,
            8'($urandom()), any_word());
    issue(ale_pkg::KIND_PUSH_BACK, 8'd0, 32'sd1);
    issue(ale_pkg::KIND_PUSH_FRONT, 8'd0, 32'sd1);
    issue(ale_pkg::KIND_INSERT, 8'd255, 32'sd1);
    issue(ale_pkg::KIND_FIND, 8'd0, shadow_list[255]);
    issue(ale_pkg::KIND_ERASE, 8'd255, 32'sd0);
    issue(ale_pkg::KIND_INSERT, 8'd255, -32'sd1);   // back to full, far end
    issue(ale_pkg::KIND_ERASE, 8'd0, 32'sd0);
    issue(ale_pkg::KIND_POP_FRONT, 8'd0, 32'sd0);
    idle_ok = 1;

    // random mix; shadow_count steers the choice of position and of find values
    for (int i = 0; i < 220; i++) begin
      n = shadow_count;
      case ($urandom_range(99)) inside
        [0:21]:  k = ale_pkg::KIND_PUSH_BACK;
        [22:31]: k = ale_pkg::KIND_PUSH_FRONT;
        [32:51]: k = ale_pkg::KIND_INSERT;
        [52:61]: k = ale_pkg::KIND_POP_BACK;
        [62:67]: k = ale_pkg::KIND_POP_FRONT;
        [68:81]: k = ale_pkg::KIND_ERASE;
        [82:97]: k = ale_pkg::KIND_FIND;
        default: k = ale_pkg::KIND_CLEAR;
      endcase
      if ($urandom_range(9) == 0) p = $urandom_range(255);
      else p = $urandom_range(n > 255 ? 255 : n);
      v = any_word();
      if (k == ale_pkg::KIND_FIND && n > 0 && $urandom_range(1))
        v = shadow_list[$urandom_range(n - 1)];
      issue(k, p[7:0], v);
    end
    start <= 1'b0;

    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("array_list_engine_unit test passed");
    else
      $display("array_list_engine_unit test failed");
    $finish;
  end
endmodule

>>> files.f
rtl/core/ale_pkg.sv
rtl/core/ale_ram.sv
rtl/core/ale_datapath.sv
rtl/core/ale_ctrl.sv
rtl/core/array_list_engine_unit.sv
tb/tb.sv
